[rtl/nmea_sentence_validator_assert.svh]
// assertion macros for the nmea sentence validator
// no dependencies; uses the clk and rst names of the including module
`ifndef NMEA_SENTENCE_VALIDATOR_ASSERT_SVH
`define NMEA_SENTENCE_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define NSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nmea_sentence_validator: assertion failed");
`define NSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmea_sentence_validator: assertion failed");
`else
`define NSV_ASSERT(label, prop)
`define NSV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/nsv_pkg.sv]
// types, character codes and header table for the nmea sentence validator
// no dependencies
package nsv_pkg;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NO_DOLLAR = 2'd1,
    ERR_FRAMING   = 2'd2,
    ERR_CHECKSUM  = 2'd3
  } err_t;

  localparam logic [2:0] TYPE_PCD     = 3'd6;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int HDR_DEPTH = 7;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_chars_t;

  localparam logic [47:0] HDR_LONG [6] = '{
    "$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG", "$PGTOP"
  };
  localparam logic [31:0] HDR_PCD = "$PCD";

  typedef struct packed {
    logic       valid_res;
    err_t       error_code;
    logic [7:0] computed_sum;
    logic [2:0] sentence_type;
  } res_t;

  function automatic logic [7:0] hex_upper(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  function automatic logic [2:0] match_header(hdr_chars_t c, logic [2:0] len,
                                              logic overlong);
    logic [47:0] six;
    logic [2:0]  kind;
    six  = {c[0], c[1], c[2], c[3], c[4], c[5]};
    kind = TYPE_UNKNOWN;
    if (!overlong) begin
      if (len == 3'd6) begin
        for (int k = 0; k < 6; k++) begin
          if (six == HDR_LONG[k]) begin
            kind = 3'(k);
          end
        end
      end
      if (len == 3'd4 && six[47:16] == HDR_PCD) begin
        kind = TYPE_PCD;
      end
    end
    return kind;
  endfunction

endpackage

[rtl/nsv_in_if.sv]
// byte input channel of the nmea sentence validator
// no dependencies
interface nsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/nsv_out_if.sv]
// result channel of the nmea sentence validator
// no dependencies
interface nsv_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [1:0] error_code;
  logic [7:0] computed_sum;
  logic [2:0] sentence_type;

  modport source (output valid, output valid_res, output error_code,
                  output computed_sum, output sentence_type, input ready);
  modport sink (input valid, input valid_res, input error_code,
                input computed_sum, input sentence_type, output ready);
endinterface

[rtl/nsv_out_buf.sv]
// two-entry result queue between the checker and the result channel
// depends on nsv_pkg and nsv_out_if
module nsv_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nsv_pkg::res_t push_data,
  output logic          full,
  nsv_out_if.source     res
);

  nsv_pkg::res_t entries [2];
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          pop;

  assign pop  = res.valid && res.ready;
  assign full = (count == 2'd2);

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign res.valid         = (count != 2'd0);
  assign res.valid_res     = entries[rd_ptr].valid_res;
  assign res.error_code    = entries[rd_ptr].error_code;
  assign res.computed_sum  = entries[rd_ptr].computed_sum;
  assign res.sentence_type = entries[rd_ptr].sentence_type;

endmodule

[rtl/nmea_sentence_validator.sv]
// nmea 0183 sentence checker: framing, checksum and header match per sentence
// depends on nsv_pkg, nsv_in_if, nsv_out_if, nsv_out_buf and the assert header
//
// rx carries one received character per transfer; res carries one result per
// sentence, produced by the transfer of the line feed that ends it. all other
// bytes produce no result.
// each byte taken enters a five-byte delay line; the running xor and the header
// capture fold in bytes as they leave it, so rx takes one byte every cycle
// while rx.ready is high. a line feed's result is shown on res once the results
// ahead of it are taken. results wait in a two-entry queue; rx.ready drops only
// in reset or while that queue is full, i.e. when res has been stalled across
// two line feeds, and rises again the cycle after a result is taken.
// reset empties the queue, clears the sentence state and holds rx.ready low;
// state is also cleared after every line feed.
`include "nmea_sentence_validator_assert.svh"

module nmea_sentence_validator (
  input  logic      clk,
  input  logic      rst,
  nsv_in_if.sink    rx,
  nsv_out_if.source res
);

  logic [7:0]         running_xor;
  logic [7:0]         running_xor_next;
  logic [7:0]         tail_window [5];
  logic [7:0]         tail_window_next [5];
  logic [2:0]         byte_count;
  logic [2:0]         byte_count_next;
  logic               starts_with_dollar;
  logic               starts_with_dollar_next;
  nsv_pkg::hdr_chars_t header_chars;
  nsv_pkg::hdr_chars_t header_chars_next;
  logic [2:0]         header_length;
  logic [2:0]         header_length_next;
  logic               header_closed;
  logic               header_closed_next;
  logic               header_overlong;
  logic               header_overlong_next;

  logic               accept;
  logic               is_lf;
  logic               take;
  logic               hdr_write;
  logic [7:0]         body_byte;
  logic               full;
  nsv_pkg::res_t      result;

  assign rx.ready  = !full && !rst;
  assign accept    = rx.valid && rx.ready;
  assign is_lf     = (rx.data_byte == nsv_pkg::CH_LF);
  assign take      = (byte_count >= 3'd5);
  assign body_byte = tail_window[0];

  always_comb begin
    running_xor_next        = running_xor;
    header_closed_next      = header_closed;
    header_overlong_next    = header_overlong;
    header_length_next      = header_length;
    header_chars_next       = header_chars;
    starts_with_dollar_next = starts_with_dollar;
    byte_count_next         = byte_count;
    hdr_write               = 1'b0;

    if (take) begin
      if (byte_count != 3'd5) begin
        running_xor_next = running_xor ^ body_byte;
      end
      if (!header_closed) begin
        if (body_byte == nsv_pkg::CH_COMMA) begin
          header_closed_next = 1'b1;
        end else if (header_length != 3'd7) begin
          hdr_write          = 1'b1;
          header_length_next = header_length + 3'd1;
        end else begin
          header_overlong_next = 1'b1;
        end
      end
    end
    for (int i = 0; i < nsv_pkg::HDR_DEPTH; i++) begin
      if (hdr_write && header_length == 3'(i)) begin
        header_chars_next[i] = body_byte;
      end
    end

    for (int i = 0; i < 4; i++) begin
      tail_window_next[i] = tail_window[i+1];
    end
    tail_window_next[4] = rx.data_byte;

    if (byte_count == 3'd0) begin
      starts_with_dollar_next = (rx.data_byte == nsv_pkg::CH_DOLLAR);
    end
    if (byte_count != 3'd6) begin
      byte_count_next = byte_count + 3'd1;
    end
  end

  always_comb begin
    result.valid_res     = 1'b0;
    result.error_code    = nsv_pkg::ERR_OK;
    result.computed_sum  = 8'd0;
    result.sentence_type = nsv_pkg::TYPE_UNKNOWN;
    if (!starts_with_dollar_next) begin
      result.error_code = nsv_pkg::ERR_NO_DOLLAR;
    end else if (byte_count_next != 3'd6 || tail_window_next[3] != nsv_pkg::CH_CR ||
                 tail_window_next[4] != nsv_pkg::CH_LF ||
                 tail_window_next[0] != nsv_pkg::CH_STAR) begin
      result.error_code = nsv_pkg::ERR_FRAMING;
    end else begin
      result.computed_sum = running_xor_next;
      if (tail_window_next[1] != nsv_pkg::hex_upper(running_xor_next[7:4]) ||
          tail_window_next[2] != nsv_pkg::hex_upper(running_xor_next[3:0])) begin
        result.error_code = nsv_pkg::ERR_CHECKSUM;
      end else begin
        result.valid_res     = 1'b1;
        result.sentence_type = nsv_pkg::match_header(header_chars_next,
                                                     header_length_next,
                                                     header_overlong_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor        <= 8'd0;
      byte_count         <= 3'd0;
      starts_with_dollar <= 1'b0;
      header_length      <= 3'd0;
      header_closed      <= 1'b0;
      header_overlong    <= 1'b0;
    end else if (accept) begin
      if (is_lf) begin
        running_xor        <= 8'd0;
        byte_count         <= 3'd0;
        starts_with_dollar <= 1'b0;
        header_length      <= 3'd0;
        header_closed      <= 1'b0;
        header_overlong    <= 1'b0;
      end else begin
        running_xor        <= running_xor_next;
        byte_count         <= byte_count_next;
        starts_with_dollar <= starts_with_dollar_next;
        header_length      <= header_length_next;
        header_closed      <= header_closed_next;
        header_overlong    <= header_overlong_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tail_window  <= tail_window_next;
      header_chars <= header_chars_next;
    end
  end

  nsv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && is_lf),
    .push_data (result),
    .full      (full),
    .res       (res)
  );

  `NSV_ASSERT(a_ok_iff_valid, res.valid |-> ((res.error_code == nsv_pkg::ERR_OK) == res.valid_res))
  `NSV_ASSERT(a_fail_unknown, res.valid && !res.valid_res |-> res.sentence_type == nsv_pkg::TYPE_UNKNOWN)
  `NSV_ASSERT(a_frame_sum_zero, res.valid && (res.error_code == nsv_pkg::ERR_NO_DOLLAR || res.error_code == nsv_pkg::ERR_FRAMING) |-> res.computed_sum == 8'd0)
  `NSV_ASSERT_NEXT(a_clear_after_lf, accept && is_lf, byte_count == 3'd0 && running_xor == 8'd0 && !header_closed)

endmodule
